/* rtl/core/lcb_pkg.sv */
// Package for the Lua comment blanker: character codes, scanner modes and
// the result word type. No dependencies.
package lcb_pkg;

    localparam int UNIT_W        = 16;
    localparam int UNIT_BITS_DEF = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    localparam logic [UNIT_W-1:0] CH_DASH   = 16'h002D;
    localparam logic [UNIT_W-1:0] CH_OPEN   = 16'h005B;
    localparam logic [UNIT_W-1:0] CH_CLOSE  = 16'h005D;
    localparam logic [UNIT_W-1:0] CH_NL     = 16'h000A;
    localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [UNIT_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [UNIT_W-1:0] CH_SQUOTE = 16'h0027;

    typedef enum logic [8:0] {
        S_NORMAL     = 9'b000000001,
        S_DASH       = 9'b000000010,
        S_LINE_START = 9'b000000100,
        S_LINE_BR    = 9'b000001000,
        S_LINE       = 9'b000010000,
        S_LONG       = 9'b000100000,
        S_LONG_BR    = 9'b001000000,
        S_STR        = 9'b010000000,
        S_STR_ESC    = 9'b100000000
    } t_mode;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              run_last;
        logic              text_end;
    } t_result;

endpackage

/* rtl/core/lua_comment_blanker.sv */
// Lua comment blanker top level: input register, scanner state machine and
// result queue. Depends on lcb_pkg.
//
// Usage: Lua source enters on the input channel one UTF-16 code unit per word
// (i_in_unit, with i_in_last on the final unit of a text). The output channel
// returns the text with every comment unit replaced by a space; newlines in
// long comments are kept. Quoted strings pass untouched.
// Each input word causes zero, one or two output words. A '-' in plain text
// that does not end the text is held until the next unit shows whether it
// opens a comment, so it causes no word; the unit after it then causes two.
// o_run_last marks the last word caused by an input word and o_text_end the
// final word of a text. An accepted input word waits in the input register
// and its results enter the result queue. Throughput: one input word per
// cycle while o_stall is low. The limit is the output channel, which moves
// one word per cycle, so an input word that causes two results needs two
// output transfers; a four-entry result queue absorbs these bursts and the
// scanner proceeds only while the queue has room for two words.
// Reset (synchronous, active low) empties the input register and the queue
// and returns the scanner to plain text. When the receiver stalls, the queue
// fills, the scanner holds its word and o_stall rises toward the sender.
// Unit bits at or above UNIT_BITS are cleared on entry.
module lua_comment_blanker
    import lcb_pkg::*;
#(
    parameter int UNIT_BITS = UNIT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [UNIT_W-1:0] i_in_unit,
    input  logic              i_in_last,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [UNIT_W-1:0] o_out_unit,
    output logic              o_run_last,
    output logic              o_text_end
);

    // Input register.
    logic              r_in_valid;
    logic [UNIT_W-1:0] r_in_unit;
    logic              r_in_last;

    // Scanner state.
    t_mode r_mode, n_mode;
    logic  r_quote, n_quote;

    // Result queue.
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;

    logic [UNIT_W-1:0] unit_mask;
    logic              in_accept;
    logic              proc_fire;
    logic              pop;
    logic [1:0]        push_cnt;
    logic [UNIT_W-1:0] res_a;
    logic [UNIT_W-1:0] res_b;
    logic [UNIT_W-1:0] quote_ch;
    logic              nrm_emit;
    t_mode             nrm_mode;
    logic              nrm_quote;
    logic              nrm_is_quote;
    t_result           wr_a;
    t_result           wr_b;

    // Mask of the code unit bits that take part in the scan.
    always_comb begin
        for (int b = 0; b < UNIT_W; b++) begin
            unit_mask[b] = (b < UNIT_BITS);
        end
    end

    // The scanner takes a word only when the queue can hold two more results.
    assign proc_fire = r_in_valid && (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_stall   = r_in_valid && !proc_fire;
    assign in_accept = i_valid && !o_stall;
    assign pop       = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in_unit <= i_in_unit & unit_mask;
            r_in_last <= i_in_last;
        end
    end

    assign quote_ch = r_quote ? CH_SQUOTE : CH_DQUOTE;

    // How a unit in plain text is handled. A quote opens a string; a dash is
    // held, unless it closes the text, in which case it goes out at once.
    always_comb begin
        nrm_is_quote = (r_in_unit == CH_DQUOTE) || (r_in_unit == CH_SQUOTE);
        nrm_emit     = 1'b1;
        nrm_mode     = S_NORMAL;
        nrm_quote    = r_quote;
        if (nrm_is_quote) begin
            nrm_mode  = S_STR;
            nrm_quote = (r_in_unit == CH_SQUOTE);
        end else if (r_in_unit == CH_DASH) begin
            nrm_emit = r_in_last;
            nrm_mode = r_in_last ? S_NORMAL : S_DASH;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_quote  = r_quote;
        push_cnt = 2'd1;
        res_a    = r_in_unit;
        res_b    = r_in_unit;
        unique case (r_mode)
            S_DASH: begin
                if (r_in_unit == CH_DASH) begin
                    res_a    = CH_SPACE;
                    res_b    = CH_SPACE;
                    push_cnt = 2'd2;
                    n_mode   = S_LINE_START;
                end else begin
                    // The held dash goes out first, then the unit as plain text.
                    res_a    = CH_DASH;
                    push_cnt = nrm_emit ? 2'd2 : 2'd1;
                    n_mode   = nrm_mode;
                    n_quote  = nrm_quote;
                end
            end
            S_LINE_START, S_LINE_BR: begin
                if (r_in_unit == CH_NL) begin
                    n_mode = S_NORMAL;
                end else if (r_in_unit == CH_OPEN) begin
                    res_a  = CH_SPACE;
                    n_mode = (r_mode == S_LINE_START) ? S_LINE_BR : S_LONG;
                end else begin
                    res_a  = CH_SPACE;
                    n_mode = S_LINE;
                end
            end
            S_LINE: begin
                if (r_in_unit == CH_NL) begin
                    n_mode = S_NORMAL;
                end else begin
                    res_a = CH_SPACE;
                end
            end
            S_LONG: begin
                if (r_in_unit != CH_NL) begin
                    res_a = CH_SPACE;
                    if (r_in_unit == CH_CLOSE) begin
                        n_mode = S_LONG_BR;
                    end
                end
            end
            S_LONG_BR: begin
                if (r_in_unit == CH_NL) begin
                    n_mode = S_LONG;
                end else begin
                    res_a  = CH_SPACE;
                    n_mode = (r_in_unit == CH_CLOSE) ? S_NORMAL : S_LONG;
                end
            end
            S_STR: begin
                if (r_in_unit == CH_BSLASH) begin
                    n_mode = S_STR_ESC;
                end else if (r_in_unit == quote_ch) begin
                    n_mode = S_NORMAL;
                end
            end
            S_STR_ESC: begin
                n_mode = S_STR;
            end
            default: begin
                push_cnt = nrm_emit ? 2'd1 : 2'd0;
                n_mode   = nrm_mode;
                n_quote  = nrm_quote;
            end
        endcase
        // The end of a text leaves the scanner ready for a new one.
        if (r_in_last) begin
            n_mode  = S_NORMAL;
            n_quote = 1'b0;
        end
    end

    always_comb begin
        wr_a.unit     = res_a;
        wr_a.run_last = (push_cnt == 2'd1);
        wr_a.text_end = (push_cnt == 2'd1) && r_in_last;
        wr_b.unit     = res_b;
        wr_b.run_last = 1'b1;
        wr_b.text_end = r_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= S_NORMAL;
            r_quote <= 1'b0;
        end else if (proc_fire) begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && (push_cnt != 2'd0)) begin
            r_fifo[r_wr_ptr] <= wr_a;
        end
        if (proc_fire && (push_cnt == 2'd2)) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= wr_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (proc_fire) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(push_cnt);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (proc_fire ? FIFO_CW'(push_cnt) : '0)
                       - FIFO_CW'(pop);
        end
    end

    assign o_valid    = (r_count != '0);
    assign o_out_unit = r_fifo[r_rd_ptr].unit;
    assign o_run_last = r_fifo[r_rd_ptr].run_last;
    assign o_text_end = r_fifo[r_rd_ptr].text_end;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue over its depth");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && (push_cnt != 2'd0) |=> o_valid)
        else $error("pushed result not presented");

    a_text_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_in_last |=> (r_mode == S_NORMAL) && !r_quote)
        else $error("scanner not back in plain text after end of text");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_text_end |-> o_run_last)
        else $error("text end on a word that is not the last of its run");

endmodule
